@@ rtl/core/triangle_face_normal_assert.svh @@
// Assertion macros of the triangle face normal RTL.
// No dependencies; included by tfn_queue, which checks itself.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TFN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tfn assertion failed");

// Next-cycle implication, disabled during reset.
`define TFN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tfn assertion failed");

`endif

@@ rtl/core/tfn_pkg.sv @@
// Types and constants of the triangle face normal block.
// No dependencies; used by every module of the block.
package tfn_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DiffW  = 17;
  localparam int unsigned ProdW  = 34;
  localparam int unsigned CrossW = 35;
  localparam int unsigned MagW   = 34;
  localparam int unsigned SqW    = 68;
  localparam int unsigned LenW   = 70;
  localparam int unsigned ScaleW = 7;
  localparam int unsigned Scale2W = 14;
  localparam int unsigned RhsW   = SqW + Scale2W;
  localparam int unsigned CmpW   = LenW + Scale2W;
  localparam int unsigned OutW   = 8;
  localparam int unsigned Steps  = 7;

  localparam logic [ScaleW-1:0]  ScaleReset  = 7'd120;
  localparam logic [Scale2W-1:0] Scale2Reset = 14'd14400;
  localparam logic [1:0]         AddrScale   = 2'd0;

  typedef struct packed {
    logic signed [DiffW-1:0] ux;
    logic signed [DiffW-1:0] uy;
    logic signed [DiffW-1:0] uz;
    logic signed [DiffW-1:0] vx;
    logic signed [DiffW-1:0] vy;
    logic signed [DiffW-1:0] vz;
  } diff_t;

  typedef struct packed {
    logic [LenW-1:0]             len2;
    logic [2:0][RhsW-1:0]        rhs;
    logic [2:0][ScaleW-1:0]      quo;
    logic [2:0][Scale2W-1:0]     quo2;
    logic [2:0]                  neg;
    logic                        degen;
  } srch_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

endpackage

@@ rtl/core/triangle_face_normal.sv @@
// Throughput: one request per cycle while the output is not stalled; the 7-stage quotient search is fully pipelined.
// A stalled output holds the back end while the front end fills the request queue.
// Reset clears all valid flags and the queue and sets the scale register scale_q to 120.
// Top level of the triangle face normal block.
// Depends on tfn_pkg, tfn_front, tfn_queue and tfn_back.
module triangle_face_normal #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz from the lowest bit up, 16 bits each.
  input  logic [143:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // nx, ny, nz from the lowest bit up, 8 bits each.
  output logic [23:0]   m_axis_tdata,
  // degenerate.
  output logic          m_axis_tuser,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [tfn_pkg::ScaleW-1:0]  scale_q;
  logic [tfn_pkg::Scale2W-1:0] scale2_q;
  logic                        cfg_wr;
  logic                        q_full, q_empty, pop;
  tfn_pkg::qctl_t              qctl;
  tfn_pkg::diff_t              front_data, queue_data;

  assign pready = 1'b1;
  assign prdata = {25'b0, scale_q};
  assign cfg_wr = psel && penable && pwrite && (paddr == tfn_pkg::AddrScale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= tfn_pkg::ScaleReset;
      scale2_q <= tfn_pkg::Scale2Reset;
    end else if (cfg_wr) begin
      scale_q  <= pwdata[6:0];
      scale2_q <= pwdata[6:0] * pwdata[6:0];
    end
  end

  tfn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_data_i (s_axis_tdata),
    .q_full_i  (q_full),
    .ctl_o     (qctl),
    .diff_o    (front_data)
  );

  tfn_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (qctl),
    .data_i (front_data),
    .full_o (q_full),
    .empty_o(q_empty),
    .pop_i  (pop),
    .data_o (queue_data)
  );

  tfn_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .pop_o      (pop),
    .data_i     (queue_data),
    .scale2_i   (scale2_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_degen_o(m_axis_tuser)
  );

endmodule

@@ rtl/core/tfn_front.sv @@
// Front end: accepts a triangle and forms its edge vectors u = b - a and v = c - b.
// Depends on tfn_pkg; feeds tfn_queue.
module tfn_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [9*tfn_pkg::CoordW-1:0]       in_data_i,
  input  logic                               q_full_i,
  output tfn_pkg::qctl_t                     ctl_o,
  output tfn_pkg::diff_t                     diff_o
);

  logic                 valid_q;
  tfn_pkg::diff_t       diff_q;
  tfn_pkg::diff_t       diff_d;
  logic signed [tfn_pkg::CoordW-1:0] ax, ay, az, bx, by_c, bz, cx, cy, cz;

  assign ax   = in_data_i[0*tfn_pkg::CoordW +: tfn_pkg::CoordW];
  assign ay   = in_data_i[1*tfn_pkg::CoordW +: tfn_pkg::CoordW];
  assign az   = in_data_i[2*tfn_pkg::CoordW +: tfn_pkg::CoordW];
  assign bx   = in_data_i[3*tfn_pkg::CoordW +: tfn_pkg::CoordW];
  assign by_c = in_data_i[4*tfn_pkg::CoordW +: tfn_pkg::CoordW];
  assign bz   = in_data_i[5*tfn_pkg::CoordW +: tfn_pkg::CoordW];
  assign cx   = in_data_i[6*tfn_pkg::CoordW +: tfn_pkg::CoordW];
  assign cy   = in_data_i[7*tfn_pkg::CoordW +: tfn_pkg::CoordW];
  assign cz   = in_data_i[8*tfn_pkg::CoordW +: tfn_pkg::CoordW];

  always_comb begin
    diff_d.ux = {bx[15], bx} - {ax[15], ax};
    diff_d.uy = {by_c[15], by_c} - {ay[15], ay};
    diff_d.uz = {bz[15], bz} - {az[15], az};
    diff_d.vx = {cx[15], cx} - {bx[15], bx};
    diff_d.vy = {cy[15], cy} - {by_c[15], by_c};
    diff_d.vz = {cz[15], cz} - {bz[15], bz};
  end

  assign ctl_o.push = valid_q && !q_full_i;
  assign ctl_o.full = q_full_i;
  assign in_ready_o = !valid_q || !q_full_i;
  assign diff_o     = diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      diff_q <= diff_d;
    end
  end

endmodule

@@ rtl/core/tfn_queue.sv @@
// Short request queue between the front end and the arithmetic back end.
// Depends on tfn_pkg and triangle_face_normal_assert.svh.
`include "triangle_face_normal_assert.svh"
module tfn_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tfn_pkg::qctl_t ctl_i,
  input  tfn_pkg::diff_t data_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output tfn_pkg::diff_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  tfn_pkg::diff_t        mem_q [Depth];
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [CntW-1:0]       cnt_q;
  logic                  push;

  assign push    = ctl_i.push;
  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `TFN_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= DepthCnt)
  `TFN_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push, cnt_q != DepthCnt)
  `TFN_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, cnt_q != '0)
  `TFN_ASSERT_NXT(a_cnt_inc, clk_i, rst_ni, push && !pop_i, cnt_q == $past(cnt_q) + 1'b1)

endmodule

@@ rtl/core/tfn_root_step.sv @@
// One bit of the quotient search for all three normal components.
// Depends on tfn_pkg; instantiated as a chain in tfn_back.
module tfn_root_step #(
  parameter int unsigned Shift = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tfn_pkg::srch_t data_i,
  output logic          valid_o,
  output tfn_pkg::srch_t data_o
);

  localparam logic [tfn_pkg::Scale2W-1:0] BitSq = tfn_pkg::Scale2W'(1) << (2 * Shift);
  localparam logic [tfn_pkg::ScaleW-1:0]  BitQ  = tfn_pkg::ScaleW'(1) << Shift;

  logic           valid_q;
  tfn_pkg::srch_t data_q, data_d;
  logic [2:0][tfn_pkg::Scale2W-1:0] t2;
  logic [2:0][tfn_pkg::CmpW-1:0]    prod;

  always_comb begin
    data_d = data_i;
    for (int k = 0; k < 3; k++) begin
      t2[k]   = data_i.quo2[k]
              + (tfn_pkg::Scale2W'(data_i.quo[k]) << (Shift + 1)) + BitSq;
      prod[k] = data_i.len2 * t2[k];
      if (prod[k] <= {2'b00, data_i.rhs[k]}) begin
        data_d.quo[k]  = data_i.quo[k] | BitQ;
        data_d.quo2[k] = t2[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/core/tfn_back.sv @@
// Back end: cross product, squared length, scaled quotient search, output.
// Depends on tfn_pkg and tfn_root_step.
module tfn_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_empty_i,
  output logic                                  pop_o,
  input  tfn_pkg::diff_t                        data_i,
  input  logic [tfn_pkg::Scale2W-1:0]           scale2_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [3*tfn_pkg::OutW-1:0]            out_data_o,
  output logic                                  out_degen_o
);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic signed [tfn_pkg::ProdW-1:0]  p_q [6];
  logic signed [tfn_pkg::CrossW-1:0] n_q [3];
  logic [tfn_pkg::SqW-1:0]           sq_q [3];
  logic [2:0]                        neg3_q;
  logic                              degen3_q;
  logic [tfn_pkg::MagW-1:0]          mag [3];
  tfn_pkg::srch_t                    s4_q, s4_d;
  logic [tfn_pkg::Steps:0]           sv;
  tfn_pkg::srch_t                    sd [tfn_pkg::Steps+1];
  logic [3*tfn_pkg::OutW-1:0]        out_q, out_d;
  logic                              degen_q;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !q_empty_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = n_q[k][tfn_pkg::CrossW-1] ? tfn_pkg::MagW'(-n_q[k]) : tfn_pkg::MagW'(n_q[k]);
    end
  end

  always_comb begin
    s4_d.len2  = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
    s4_d.quo   = '0;
    s4_d.quo2  = '0;
    s4_d.neg   = neg3_q;
    s4_d.degen = degen3_q;
    for (int k = 0; k < 3; k++) begin
      s4_d.rhs[k] = sq_q[k] * scale2_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= pop_o;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= sv[tfn_pkg::Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= data_i.uy * data_i.vz;
      p_q[1] <= data_i.uz * data_i.vy;
      p_q[2] <= data_i.uz * data_i.vx;
      p_q[3] <= data_i.ux * data_i.vz;
      p_q[4] <= data_i.ux * data_i.vy;
      p_q[5] <= data_i.uy * data_i.vx;
      for (int k = 0; k < 3; k++) begin
        n_q[k]    <= {p_q[2*k][tfn_pkg::ProdW-1], p_q[2*k]}
                   - {p_q[2*k+1][tfn_pkg::ProdW-1], p_q[2*k+1]};
        sq_q[k]   <= mag[k] * mag[k];
        neg3_q[k] <= n_q[k][tfn_pkg::CrossW-1];
      end
      degen3_q <= (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
      s4_q     <= s4_d;
      out_q    <= out_d;
      degen_q  <= sd[tfn_pkg::Steps].degen;
    end
  end

  assign sv[0] = v4_q;
  assign sd[0] = s4_q;

  for (genvar g = 0; g < tfn_pkg::Steps; g++) begin : g_step
    tfn_root_step #(
      .Shift(tfn_pkg::Steps - 1 - g)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sv[g]),
      .data_i (sd[g]),
      .valid_o(sv[g+1]),
      .data_o (sd[g+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (sd[tfn_pkg::Steps].degen) begin
        out_d[k*tfn_pkg::OutW +: tfn_pkg::OutW] = '0;
      end else if (sd[tfn_pkg::Steps].neg[k]) begin
        out_d[k*tfn_pkg::OutW +: tfn_pkg::OutW] = -{1'b0, sd[tfn_pkg::Steps].quo[k]};
      end else begin
        out_d[k*tfn_pkg::OutW +: tfn_pkg::OutW] = {1'b0, sd[tfn_pkg::Steps].quo[k]};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_degen_o = degen_q;

endmodule

@@ bench/tb_triangle_face_normal.sv @@
// Testbench for triangle_face_normal: sends triangles over the input stream and
// compares every returned normal against a predictor of exact truncated scaling.
// Depends on tfn_pkg and the triangle_face_normal RTL.
`timescale 1ns / 1ps

typedef struct {
  bit [7:0] nx;
  bit [7:0] ny;
  bit [7:0] nz;
  bit       degen;
} normal_t;

class face_normal_board;
  normal_t pending[$];
  int      errors;
  int      checked;
  int      degens;

  function bit [7:0] scale_comp(longint d, bit [127:0] len2, bit [6:0] s);
    bit [127:0] m;
    bit [127:0] rhs;
    bit [127:0] t;
    bit [127:0] q;
    bit [127:0] bt;
    m   = (d < 0) ? -d : d;
    rhs = m * m * s * s;
    q   = 0;
    for (bt = 64; bt != 0; bt = bt >> 1) begin
      t = q | bt;
      if (t <= s && len2 * t * t <= rhs) q = t;
    end
    return (d < 0) ? -q[7:0] : q[7:0];
  endfunction

  function void note_triangle(bit [143:0] tri_bits, bit [6:0] s);
    longint  c [9];
    longint  ux, uy, uz, vx, vy, vz, cxp, cyp, czp;
    bit [127:0] mx, my, mz;
    bit [127:0] len2;
    normal_t r;
    for (int i = 0; i < 9; i++) c[i] = longint'($signed(tri_bits[16*i +: 16]));
    ux = c[3] - c[0]; uy = c[4] - c[1]; uz = c[5] - c[2];
    vx = c[6] - c[3]; vy = c[7] - c[4]; vz = c[8] - c[5];
    cxp = uy * vz - uz * vy;
    cyp = uz * vx - ux * vz;
    czp = ux * vy - uy * vx;
    mx = (cxp < 0) ? -cxp : cxp;
    my = (cyp < 0) ? -cyp : cyp;
    mz = (czp < 0) ? -czp : czp;
    len2 = mx * mx + my * my + mz * mz;
    if (len2 == 0) begin
      r = '{8'd0, 8'd0, 8'd0, 1'b1};
    end else begin
      r.nx = scale_comp(cxp, len2, s);
      r.ny = scale_comp(cyp, len2, s);
      r.nz = scale_comp(czp, len2, s);
      r.degen = 1'b0;
    end
    pending.push_back(r);
  endfunction

  function void check_normal(bit [23:0] data, bit user);
    normal_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected normal %h deg %0b", $time, data, user);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (e.degen) degens++;
    if (data !== {e.nz, e.ny, e.nx} || user !== e.degen) begin
      $display("%0t: mismatch expected nx %0d ny %0d nz %0d deg %0b,",
               $time, $signed(e.nx), $signed(e.ny), $signed(e.nz), e.degen);
      $display("  got nx %0d ny %0d nz %0d deg %0b",
               $signed(data[7:0]), $signed(data[15:8]), $signed(data[23:16]), user);
      errors++;
    end
  endfunction
endclass

module tb_triangle_face_normal;

  localparam int WatchLimit = 4000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [1:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  face_normal_board board = new();
  bit [6:0] cur_scale = tfn_pkg::ScaleReset;
  bit       quiet = 1'b0;
  int       sent = 0;
  int       idle_cycles = 0;
  int       rx_hold = 0;

  triangle_face_normal u_top (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_triangle(s_axis_tdata, cur_scale);
      if (m_axis_tvalid && m_axis_tready) board.check_normal(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!quiet && rx_hold == 0 && $urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 16);
    if (rx_hold > 0 && !quiet) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else begin
      rx_hold = 0;
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_triangle(bit [143:0] tri_bits);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tri_bits;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_scale(bit [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= tfn_pkg::AddrScale; pwdata <= v; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    cur_scale = v[6:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic bit [143:0] pack_tri(int a[9]);
    bit [143:0] t;
    for (int i = 0; i < 9; i++) t[16*i +: 16] = 16'(a[i]);
    return t;
  endfunction

  function automatic bit [143:0] random_tri();
    int a[9];
    int d[3];
    int k;
    case ($urandom_range(0, 9))
      5, 6: for (int i = 0; i < 9; i++) a[i] = $urandom_range(0, 16) - 8;
      7: begin
        k = $urandom_range(0, 6) - 3;
        for (int i = 0; i < 3; i++) begin
          d[i] = $urandom_range(0, 200) - 100;
          a[i] = $urandom_range(0, 2000) - 1000;
          a[i+3] = a[i] + d[i];
          a[i+6] = a[i+3] + k * d[i];
        end
      end
      8: begin
        for (int i = 0; i < 9; i++) a[i] = $urandom_range(0, 65535);
        k = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) a[3*((k+1)%3)+i] = a[3*k+i];
      end
      9: for (int i = 0; i < 9; i++)
           a[i] = $urandom_range(0, 1) ? -32768 + $urandom_range(0, 2)
                                       : 32767 - $urandom_range(0, 2);
      default: for (int i = 0; i < 9; i++) a[i] = $urandom_range(0, 65535);
    endcase
    return pack_tri(a);
  endfunction

  initial begin
    bit [31:0] scales [6];
    int fixed [15][9];
    scales = '{32'd120, 32'd1, 32'd127, 32'd0, 32'd0, 32'h0000_01C8};
    scales[4] = $urandom_range(2, 126);
    fixed = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 1, 0, 0, 0, 1, 0},
      '{0, 0, 0, 0, 1, 0, 0, 0, 1},
      '{0, 0, 0, 0, 0, 1, 1, 0, 0},
      '{0, 0, 0, 0, 1, 0, 1, 0, 0},
      '{-32768, -32768, -32768, 32767, -32768, -32768, 32767, 32767, -32768},
      '{-32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767},
      '{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768},
      '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768},
      '{1, 2, 3, 2, 4, 6, 3, 6, 9},
      '{5, 5, 5, 5, 5, 5, 7, -3, 2},
      '{0, 0, 0, 1, 1, 1, 1, 1, 0},
      '{0, 0, 0, 3, 4, 0, 0, 0, 5},
      '{-32768, 0, 0, 32767, 0, 0, 32767, 32767, 32767},
      '{100, -200, 300, -400, 500, -600, 700, -800, 900}
    };
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        write_scale(scales[p]);
      end
      quiet = (p == 5);
      foreach (fixed[i]) send_triangle(pack_tri(fixed[i]));
      for (int n = 0; n < 160; n++) begin
        if (p == 2 && n == 80) drain();
        send_triangle(random_tri());
      end
    end
    drain();
    $display("Sent %0d triangles over six scale settings (1, 127, 0 and others).", sent);
    $display("Checked %0d normals, %0d of them degenerate.", board.checked, board.degens);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
